// ===== hw/rtl/cva_pkg.sv =====
// shared types and constants of the contiguous vector allocator
// depends on nothing; used by cva_map and contiguous_vector_allocator_top
package cva_pkg;

    localparam int VECTOR_COUNT = 224;
    localparam int IDX_W = (VECTOR_COUNT > 1) ? $clog2(VECTOR_COUNT) : 1;
    localparam int CNT_W = $clog2(VECTOR_COUNT + 1);

    // request codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RESERVE = 2'd1;
    localparam logic [1:0] OP_FREE    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_RUN = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_SAME   = 2'd3;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // write port of the allocation map
    typedef struct packed {
        logic en;
        idx_t addr;
        logic taken;
    } map_wr_t;

endpackage

// ===== hw/rtl/contiguous_vector_allocator_top.sv =====
// top level of the contiguous vector allocator: sequencer, scan counter, result register
// depends on cva_pkg and cva_map
//
// First-fit allocator over a map of VECTOR_COUNT taken bits, all free after reset.
// Each input transaction is one request; each produces exactly one result transaction.
// Allocate (operation 0) scans the map from vector 0 upward, one entry per cycle through
// the single map read port, tracking the current run of free entries; the first run of
// run_length free entries that lies wholly inside the table is then marked taken, one
// entry per cycle through the map write port, and its start returned. A zero run_length
// returns the lowest free vector and marks nothing. Reserve (1) and free (2) read and
// write one entry; out-of-range vectors and operation 3 go straight to the result.
// The result cycle stretches while the output register still holds an unaccepted result.
// The block accepts one request at a time: s_tready is high only while the sequencer is
// idle. A finished result waits in the output register while the next request is taken in.
module contiguous_vector_allocator_top
    import cva_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // operation[1:0], run_length[9:2], vector[17:10], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], first_vector[9:2], zero pad
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SGL_RD = 6'b000010,
        S_SGL_WR = 6'b000100,
        S_SCAN   = 6'b001000,
        S_MARK   = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // latched request
    logic [1:0] op_reg, op_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] vec_reg, vec_next;

    // scan bookkeeping
    cnt_t       issue_idx_reg, issue_idx_next;   // next entry to read
    logic       chk_vld_reg, chk_vld_next;       // a read is in flight
    idx_t       chk_idx_reg, chk_idx_next;       // entry of that read
    cnt_t       run_start_reg, run_start_next;   // start of current free run
    cnt_t       run_cnt_reg, run_cnt_next;       // length of current free run

    // marking
    idx_t       mark_idx_reg, mark_idx_next;
    logic [7:0] mark_left_reg, mark_left_next;

    // pending result
    logic [1:0] res_status_reg, res_status_next;
    logic [7:0] res_first_reg, res_first_next;

    // output register
    logic       m_tvalid_reg, m_tvalid_next;
    logic [1:0] m_status_reg, m_status_next;
    logic [7:0] m_first_reg, m_first_next;

    // map ports
    logic    rd_en;
    idx_t    rd_addr;
    logic    rd_taken;
    map_wr_t map_wr;

    logic       s_accept;
    logic       out_free;
    logic       issue;
    logic       vec_oob;
    logic [1:0] in_op;
    logic [7:0] in_len;
    logic [7:0] in_vec;

    cva_map u_map (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_taken (rd_taken),
        .wr       (map_wr)
    );

    assign in_op    = s_tdata[1:0];
    assign in_len   = s_tdata[9:2];
    assign in_vec   = s_tdata[17:10];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // scan issues a read while entries remain
    assign issue   = (state_reg == S_SCAN) && (issue_idx_reg < CNT_W'(VECTOR_COUNT));
    assign vec_oob = {1'b0, vec_reg} >= 9'(VECTOR_COUNT);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        len_next        = len_reg;
        vec_next        = vec_reg;
        issue_idx_next  = issue_idx_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        run_start_next  = run_start_reg;
        run_cnt_next    = run_cnt_reg;
        mark_idx_next   = mark_idx_reg;
        mark_left_next  = mark_left_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_first_next    = m_first_reg;
        rd_en           = 1'b0;
        rd_addr         = vec_reg[IDX_W-1:0];
        map_wr.en       = 1'b0;
        map_wr.addr     = mark_idx_reg;
        map_wr.taken    = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    op_next         = in_op;
                    len_next        = in_len;
                    vec_next        = in_vec;
                    res_status_next = ST_OK;
                    res_first_next  = '0;
                    issue_idx_next  = '0;
                    run_start_next  = '0;
                    run_cnt_next    = '0;
                    case (in_op)
                        OP_ALLOC: state_next = S_SCAN;
                        OP_RESERVE, OP_FREE: begin
                            if ({1'b0, in_vec} >= 9'(VECTOR_COUNT)) begin
                                res_status_next = ST_RANGE;
                                state_next      = S_RESULT;
                            end else begin
                                state_next = S_SGL_RD;
                            end
                        end
                        default: state_next = S_RESULT;   // code 3 is a no-op
                    endcase
                end
            end

            S_SGL_RD: begin
                rd_en      = !vec_oob;
                state_next = S_SGL_WR;
            end

            S_SGL_WR: begin
                map_wr.en    = 1'b1;
                map_wr.addr  = vec_reg[IDX_W-1:0];
                map_wr.taken = (op_reg == OP_RESERVE);
                res_status_next = (rd_taken == map_wr.taken) ? ST_SAME : ST_OK;
                state_next      = S_RESULT;
            end

            S_SCAN: begin
                rd_en        = issue;
                rd_addr      = issue_idx_reg[IDX_W-1:0];
                chk_vld_next = issue;
                chk_idx_next = issue_idx_reg[IDX_W-1:0];
                if (issue) begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                if (chk_vld_reg) begin
                    if (len_reg == 8'd0) begin
                        // lowest free entry, nothing marked
                        if (!rd_taken) begin
                            res_first_next = 8'(chk_idx_reg);
                            state_next     = S_RESULT;
                        end
                    end else if (!rd_taken) begin
                        if (9'(run_cnt_reg) + 9'd1 == {1'b0, len_reg}) begin
                            mark_idx_next  = run_start_reg[IDX_W-1:0];
                            mark_left_next = len_reg;
                            res_first_next = 8'(run_start_reg);
                            state_next     = S_MARK;
                        end else begin
                            run_cnt_next = run_cnt_reg + 1'b1;
                        end
                    end else begin
                        run_cnt_next   = '0;
                        run_start_next = CNT_W'(chk_idx_reg) + 1'b1;
                    end
                end else if (!issue && (issue_idx_reg != '0)) begin
                    // table exhausted with no fit
                    res_status_next = ST_NO_RUN;
                    res_first_next  = '0;
                    state_next      = S_RESULT;
                end
            end

            S_MARK: begin
                map_wr.en = 1'b1;
                if (mark_left_reg == 8'd1) begin
                    state_next = S_RESULT;
                end else begin
                    mark_idx_next  = mark_idx_reg + 1'b1;
                    mark_left_next = mark_left_reg - 8'd1;
                end
            end

            S_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_first_next  = res_first_reg;
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            chk_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            chk_vld_reg  <= chk_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        len_reg        <= len_next;
        vec_reg        <= vec_next;
        issue_idx_reg  <= issue_idx_next;
        chk_idx_reg    <= chk_idx_next;
        run_start_reg  <= run_start_next;
        run_cnt_reg    <= run_cnt_next;
        mark_idx_reg   <= mark_idx_next;
        mark_left_reg  <= mark_left_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        m_status_reg   <= m_status_next;
        m_first_reg    <= m_first_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_first_reg, m_status_reg};

`ifndef SYNTHESIS
    // an accepted request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("block ready right after accepting a request");

    // the map is written only while marking or doing a single-entry update
    a_map_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        map_wr.en |-> (state_reg == S_MARK || state_reg == S_SGL_WR))
        else $error("map written outside mark or single update");

    // a result leaving the sequencer lands in the output register
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && out_free) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("result not loaded into output register");

    // marking always has at least one entry left
    a_mark_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MARK) |-> (mark_left_reg != 8'd0))
        else $error("marking with an empty run");
`endif

endmodule

// ===== hw/rtl/cva_map.sv =====
// allocation map: one taken bit per vector, one read and one write port
// depends on cva_pkg
module cva_map
    import cva_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    rd_en,
    input  idx_t    rd_addr,
    output logic    rd_taken,
    input  map_wr_t wr
);

    logic                    mem [VECTOR_COUNT];
    logic [VECTOR_COUNT-1:0] vld_reg;
    logic                    mem_q_reg;
    logic                    vld_q_reg;

    // storage without reset, entries never written read as free
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.taken;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                vld_q_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_taken = mem_q_reg & vld_q_reg;

endmodule
